[hdl/ksel_pkg.sv]
// shared types, widths and state codes for the rank selection block
`timescale 1ns / 1ps

package ksel_pkg;

    // store capacity and derived index/count widths
    localparam int MAX_ITEMS = 1024;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VALUE_W   = 48;
    localparam int RANK_W    = 11;
    localparam int RC_W      = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    // input item
    typedef struct packed {
        logic [VALUE_W-1:0] sample_value;
        logic               is_last;
        logic [RANK_W-1:0]  wanted_rank;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [VALUE_W-1:0] selected_value;
        logic               overflowed;
    } t_out_item;

    // store access request for the write and read ports
    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [VALUE_W-1:0] wdata;
        logic [IDX_W-1:0]   raddr;
    } t_ram_req;

    // controller states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PART,
        ST_PIVOT,
        ST_CMP,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_FIN_RD,
        ST_FIN_A,
        ST_FIN_B,
        ST_KREAD,
        ST_EMIT
    } t_state;

endpackage

[hdl/ksel_ram.sv]
// value store: one write port, one read port with registered read data
`timescale 1ns / 1ps

module ksel_ram
    import ksel_pkg::*;
(
    input  logic               i_clk,
    input  t_ram_req           i_req,
    output logic [VALUE_W-1:0] o_rdata
);

    logic [VALUE_W-1:0] r_mem [MAX_ITEMS];
    logic [VALUE_W-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/kth_smallest_select.sv]
// rank selection by lomuto quickselect over a loaded value store
// load: one value per cycle in the load state, written into the store unless it is full
// select: read pivot, compare each scanned entry, swap with two writes, place pivot;
//   average linear, worst case quadratic in the set size, bound by the one store write port
// result sits in an output register, so the next set may load while it waits
// reset (synchronous, active low) clears count, overflow flag, state and output valid;
//   the store itself is not cleared
`timescale 1ns / 1ps

module kth_smallest_select
    import ksel_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;
    logic [IDX_W-1:0]   r_lo, n_lo;
    logic [IDX_W-1:0]   r_hi, n_hi;
    logic [IDX_W-1:0]   r_k, n_k;
    logic [IDX_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [VALUE_W-1:0] r_pivot, n_pivot;
    logic [VALUE_W-1:0] r_aj, n_aj;
    logic [VALUE_W-1:0] r_ai, n_ai;
    logic [VALUE_W-1:0] r_res_val, n_res_val;
    logic               r_res_ovf, n_res_ovf;
    t_out_item          r_out;
    logic               r_out_valid;

    t_ram_req           ram_req;
    logic [VALUE_W-1:0] ram_rdata;
    logic               in_xfer;
    logic               out_load;
    logic               store_full;
    logic [CNT_W-1:0]   count_after;
    logic [RC_W-1:0]    rank_nz;
    logic [RC_W-1:0]    rank_eff;
    logic [IDX_W-1:0]   j_next;
    logic               j_done;
    logic               le_pivot;

    ksel_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready = (r_state == ST_LOAD);
    assign in_xfer    = i_in_valid && o_in_ready;

    // rank clamp for the closing item
    assign store_full  = (r_count >= CNT_W'(MAX_ITEMS));
    assign count_after = store_full ? r_count : r_count + CNT_W'(1);
    assign rank_nz     = (i_in_data.wanted_rank == '0) ? RC_W'(1)
                                                       : RC_W'(i_in_data.wanted_rank);
    assign rank_eff    = (rank_nz > RC_W'(count_after)) ? RC_W'(count_after) : rank_nz;

    // scan helpers
    assign j_next   = r_j + IDX_W'(1);
    assign j_done   = (j_next == r_hi);
    assign le_pivot = (ram_rdata <= r_pivot);

    // next state, store access and datapath updates
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_k       = r_k;
        n_i       = r_i;
        n_j       = r_j;
        n_pivot   = r_pivot;
        n_aj      = r_aj;
        n_ai      = r_ai;
        n_res_val = r_res_val;
        n_res_ovf = r_res_ovf;
        out_load  = 1'b0;
        ram_req.we    = 1'b0;
        ram_req.waddr = r_i;
        ram_req.wdata = r_aj;
        ram_req.raddr = r_j;

        case (r_state)
            ST_LOAD: begin
                if (in_xfer) begin
                    if (!store_full) begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = r_count[IDX_W-1:0];
                        ram_req.wdata = i_in_data.sample_value;
                        n_count       = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.is_last) begin
                        n_k       = IDX_W'(rank_eff - RC_W'(1));
                        n_hi      = IDX_W'(count_after - CNT_W'(1));
                        n_lo      = '0;
                        n_res_ovf = r_ovf || store_full;
                        n_count   = '0;
                        n_ovf     = 1'b0;
                        n_state   = ST_PART;
                    end
                end
            end
            ST_PART: begin
                if (r_lo < r_hi) begin
                    ram_req.raddr = r_hi;
                    n_state       = ST_PIVOT;
                end else begin
                    ram_req.raddr = r_k;
                    n_state       = ST_KREAD;
                end
            end
            ST_PIVOT: begin
                n_pivot       = ram_rdata;
                n_i           = r_lo;
                n_j           = r_lo;
                ram_req.raddr = r_lo;
                n_state       = ST_CMP;
            end
            ST_CMP: begin
                n_aj = ram_rdata;
                if (le_pivot && (r_i != r_j)) begin
                    ram_req.raddr = r_i;
                    n_state       = ST_SWAP_A;
                end else begin
                    if (le_pivot) begin
                        n_i = r_i + IDX_W'(1);
                    end
                    n_j = j_next;
                    if (j_done) begin
                        n_state = ST_FIN_RD;
                    end else begin
                        ram_req.raddr = j_next;
                    end
                end
            end
            ST_SWAP_A: begin
                n_ai          = ram_rdata;
                ram_req.we    = 1'b1;
                ram_req.waddr = r_i;
                ram_req.wdata = r_aj;
                n_state       = ST_SWAP_B;
            end
            ST_SWAP_B: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_j;
                ram_req.wdata = r_ai;
                n_i           = r_i + IDX_W'(1);
                n_j           = j_next;
                if (j_done) begin
                    n_state = ST_FIN_RD;
                end else begin
                    ram_req.raddr = j_next;
                    n_state       = ST_CMP;
                end
            end
            ST_FIN_RD: begin
                ram_req.raddr = r_i;
                n_state       = ST_FIN_A;
            end
            ST_FIN_A: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_hi;
                ram_req.wdata = ram_rdata;
                n_state       = ST_FIN_B;
            end
            ST_FIN_B: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_i;
                ram_req.wdata = r_pivot;
                if (r_i == r_k) begin
                    n_res_val = r_pivot;
                    n_state   = ST_EMIT;
                end else if (r_k < r_i) begin
                    n_hi    = r_i - IDX_W'(1);
                    n_state = ST_PART;
                end else begin
                    n_lo    = r_i + IDX_W'(1);
                    n_state = ST_PART;
                end
            end
            ST_KREAD: begin
                n_res_val = ram_rdata;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_k       <= n_k;
        r_i       <= n_i;
        r_j       <= n_j;
        r_pivot   <= n_pivot;
        r_aj      <= n_aj;
        r_ai      <= n_ai;
        r_res_val <= n_res_val;
        r_res_ovf <= n_res_ovf;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.selected_value <= r_res_val;
            r_out.overflowed     <= r_res_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // target rank stays inside the active window
    a_k_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PART || r_state == ST_PIVOT || r_state == ST_CMP)
        |-> (r_lo <= r_k && r_k <= r_hi))
        else $error("rank left the partition window");

    // scan pointers ordered inside the window
    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (r_lo <= r_i && r_i <= r_j && r_j < r_hi))
        else $error("scan pointers out of order");

    // fill count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ITEMS))
        else $error("fill count beyond capacity");

    // a finished selection always shows up at the output
    a_emit_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out_valid)
        else $error("result not presented after emit");

endmodule

[sim/tb.sv]
// self-checking testbench for the kth_smallest_select rank selection block
`timescale 1ns / 1ps

module tb;
    import ksel_pkg::*;

    // ways to draw the values of one set
    typedef enum int {
        VAL_WIDE,
        VAL_NARROW,
        VAL_EDGE
    } t_val_mode;

    localparam logic [VALUE_W-1:0] VAL_MAX  = '1;
    localparam logic [RANK_W-1:0]  RANK_MAX = '1;
    // sets of at most 40 samples keep even a quadratic selection short, so the whole run
    // with worst-case gaps stays well inside this watchdog limit
    localparam int unsigned LIMIT_CYCLES = 1_000_000;

    logic      i_clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    kth_smallest_select dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // stimulus and expected results
    t_in_item    sample_feed_q[$];
    t_out_item   rank_result_q[$];
    int unsigned feed_total;
    int unsigned accepted_cnt;
    int unsigned results_checked;
    int unsigned ovf_sets;
    int unsigned mismatches;

    // predictor state: values of the set being loaded
    logic [VALUE_W-1:0] set_store [MAX_ITEMS];
    int unsigned        set_count;
    bit                 set_ovf;

    // handshake bookkeeping between monitor and driver
    bit          in_taken;
    bit          calm;
    int unsigned drv_cycle;
    int unsigned in_gap;
    int unsigned out_hold;
    int unsigned out_stall;

    // lomuto quickselect over set_store[0..n-1], k is 0-based
    function automatic logic [VALUE_W-1:0] rank_value(int unsigned n, int unsigned k);
        int unsigned        lo;
        int unsigned        hi;
        int unsigned        i;
        int unsigned        q;
        logic [VALUE_W-1:0] pivot;
        logic [VALUE_W-1:0] tmp;
        lo = 0;
        hi = n - 1;
        while (lo < hi) begin
            pivot = set_store[hi];
            i = lo;
            for (int unsigned j = lo; j < hi; j++) begin
                if (set_store[j] <= pivot) begin
                    tmp = set_store[i];
                    set_store[i] = set_store[j];
                    set_store[j] = tmp;
                    i++;
                end
            end
            tmp = set_store[i];
            set_store[i] = set_store[hi];
            set_store[hi] = tmp;
            q = i;
            if (q == k)
                return set_store[q];
            if (k < q)
                hi = q - 1;
            else
                lo = q + 1;
        end
        return set_store[k];
    endfunction

    // store one accepted sample, predict the selection on the closing one
    function automatic void absorb_sample(t_in_item it);
        int unsigned rank;
        t_out_item   want;
        if (set_count < MAX_ITEMS) begin
            set_store[set_count] = it.sample_value;
            set_count++;
        end else begin
            set_ovf = 1'b1;
        end
        if (it.is_last) begin
            rank = 32'(it.wanted_rank);
            if (rank == 0)
                rank = 1;
            if (rank > set_count)
                rank = set_count;
            want.selected_value = rank_value(set_count, rank - 1);
            want.overflowed = set_ovf;
            rank_result_q.push_back(want);
            if (set_ovf)
                ovf_sets++;
            set_count = 0;
            set_ovf = 1'b0;
        end
    endfunction

    // compare one result transfer against the oldest prediction
    function automatic void check_selection(t_out_item got);
        t_out_item want;
        if (rank_result_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: value %h overflow %0b",
                         got.selected_value, got.overflowed);
            return;
        end
        want = rank_result_q.pop_front();
        results_checked++;
        if (got.selected_value !== want.selected_value
            || got.overflowed !== want.overflowed) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: expected value %h overflow %0b, got value %h overflow %0b",
                         results_checked, want.selected_value, want.overflowed,
                         got.selected_value, got.overflowed);
        end
    endfunction

    // mostly short gaps, a few long ones, none during calm stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] gen_value(t_val_mode mode);
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case (mode)
            VAL_NARROW: return VALUE_W'($urandom_range(0, 7));
            VAL_EDGE: begin
                case ($urandom_range(4))
                    0: return '0;
                    1: return VAL_MAX;
                    2: return VAL_MAX - VALUE_W'(1);
                    3: return VALUE_W'(1);
                    default: return wide[VALUE_W-1:0];
                endcase
            end
            default: return wide[VALUE_W-1:0];
        endcase
    endfunction

    // queue one sample; rank on non-closing samples is ignored by the block
    function automatic void push_sample(logic [VALUE_W-1:0] v, bit last,
                                        logic [RANK_W-1:0] rank);
        t_in_item it;
        it.sample_value = v;
        it.is_last = last;
        it.wanted_rank = last ? rank : RANK_W'($urandom);
        sample_feed_q.push_back(it);
    endfunction

    function automatic void push_set(int unsigned n, t_val_mode mode, logic [RANK_W-1:0] rank);
        for (int unsigned k = 1; k <= n; k++)
            push_sample(gen_value(mode), k == n, rank);
    endfunction

    // driver: inputs change on the falling edge
    always @(negedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            out_ready <= 1'b0;
        end else begin
            drv_cycle++;
            if (drv_cycle % 400 == 0)
                calm = ($urandom_range(3) == 0);
            // input channel
            if (!in_valid || in_taken) begin
                if (in_gap != 0) begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (sample_feed_q.size() != 0) begin
                    in_data <= sample_feed_q.pop_front();
                    in_valid <= 1'b1;
                    in_gap <= pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
            // result channel back-pressure
            if (out_hold != 0) begin
                out_hold <= out_hold - 1;
            end else if (out_ready) begin
                out_stall = pick_gap();
                if (out_stall == 0) begin
                    out_hold <= $urandom_range(0, 7);
                end else begin
                    out_ready <= 1'b0;
                    out_hold <= out_stall - 1;
                end
            end else begin
                out_ready <= 1'b1;
                out_hold <= $urandom_range(0, 15);
            end
        end
    end

    // monitor: both channels sampled on the rising edge
    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (rst_n) begin
            if (out_valid && out_ready)
                check_selection(out_data);
            if (in_valid && in_ready) begin
                in_taken = 1'b1;
                accepted_cnt++;
                absorb_sample(in_data);
            end
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        // single sample at the top of the range, rank zero acts as rank one
        push_sample(VAL_MAX, 1'b1, '0);
        // single zero sample
        push_sample('0, 1'b1, RANK_W'(1));
        // median of three
        push_sample(VALUE_W'(5), 1'b0, '0);
        push_sample(VALUE_W'(1), 1'b0, '0);
        push_sample(VALUE_W'(9), 1'b1, RANK_W'(2));
        // all equal values
        for (int k = 0; k < 4; k++)
            push_sample(VALUE_W'(7), k == 3, RANK_W'(3));
        // extremes with ties, rank far above the count
        push_sample(VAL_MAX, 1'b0, '0);
        push_sample('0, 1'b0, '0);
        push_sample(VAL_MAX, 1'b0, '0);
        push_sample('0, 1'b0, '0);
        push_sample(VALUE_W'(123), 1'b1, RANK_MAX);
        // already sorted, smallest wanted
        for (int k = 1; k <= 3; k++)
            push_sample(VALUE_W'(k), k == 3, RANK_W'(1));
        // reverse sorted, rank of exactly the capacity
        for (int k = 4; k >= 1; k--)
            push_sample(VALUE_W'(k), k == 1, 11'd1024);

        // random sets, mostly small
        while (sample_feed_q.size() < 750) begin
            int unsigned n;
            int unsigned r;
            t_val_mode   mode;
            r = $urandom_range(99);
            n = (r < 70) ? $urandom_range(1, 8) :
                (r < 95) ? $urandom_range(9, 24) : $urandom_range(25, 40);
            mode = t_val_mode'($urandom_range(2));
            r = $urandom_range(99);
            if (r < 15)
                push_set(n, mode, '0);
            else if (r < 30)
                push_set(n, mode, RANK_W'($urandom_range(n + 1, RANK_MAX)));
            else
                push_set(n, mode, RANK_W'($urandom_range(1, n)));
        end
        feed_total = sample_feed_q.size();

        // reset
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        while (accepted_cnt != feed_total || rank_result_q.size() != 0)
            @(negedge i_clk);
        repeat (200) @(negedge i_clk);

        $display("covered %0d samples in %0d selections, %0d of them with dropped samples",
                 accepted_cnt, results_checked, ovf_sets);
        $display("ranks included zero, over-count and full-capacity cases, with random stalls");
        if (mismatches == 0 && rank_result_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
hdl/ksel_pkg.sv
hdl/ksel_ram.sv
hdl/kth_smallest_select.sv
sim/tb.sv
